// ===== rtl/sjtrc_pkg.sv =====
package sjtrc_pkg;

	localparam logic [31:0] LEN_MAX_DEF = 32'd65535;
	localparam logic [15:0] MIN_TEXT    = 16'd4;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] PRINT_LO    = 8'h20;
	localparam logic [7:0] PRINT_HI    = 8'h7E;
	localparam logic [7:0] KANA_LO     = 8'hA1;
	localparam logic [7:0] KANA_HI     = 8'hDF;
	localparam logic [7:0] LEAD_A_LO   = 8'h81;
	localparam logic [7:0] LEAD_A_HI   = 8'h9F;
	localparam logic [7:0] LEAD_B_LO   = 8'hE0;
	localparam logic [7:0] LEAD_B_HI   = 8'hEF;
	localparam logic [7:0] TRAIL_A_LO  = 8'h40;
	localparam logic [7:0] TRAIL_A_HI  = 8'h7E;
	localparam logic [7:0] TRAIL_B_LO  = 8'h80;
	localparam logic [7:0] TRAIL_B_HI  = 8'hFC;

	function automatic logic single_byte_ok(input logic [7:0] b);
		return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
			((b >= PRINT_LO) && (b <= PRINT_HI)) ||
			((b >= KANA_LO) && (b <= KANA_HI));
	endfunction

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) ||
			((b >= LEAD_B_LO) && (b <= LEAD_B_HI));
	endfunction

	function automatic logic second_byte_ok(input logic [7:0] b);
		return ((b >= TRAIL_A_LO) && (b <= TRAIL_A_HI)) ||
			((b >= TRAIL_B_LO) && (b <= TRAIL_B_HI));
	endfunction

endpackage

// ===== rtl/sjis_text_record_check.sv =====
// The result of a record is registered and appears on out_valid in the cycle after its last byte is taken.
// Throughput: one byte per cycle while in_stall is low; the counters and flags update in a single pass per byte.
// A last byte waits only while the result register holds an earlier result that is stalled.
// Reset (arst_n low, asynchronous) clears the counters, the flags and out_valid; the result data is not reset.
module sjis_text_record_check #(
	parameter logic [31:0] LEN_MAX = sjtrc_pkg::LEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        recognized,
	output logic [15:0] text_length,
	output logic [15:0] pad_length
);
	import sjtrc_pkg::*;

	localparam logic [15:0] CNT_CAP = (LEN_MAX < 32'd65535) ? LEN_MAX[15:0] : 16'hFFFF;

	typedef struct packed {
		logic [15:0] byte_total;
		logic [15:0] nul_run;
		logic        lead_pending;
		logic        record_bad;
		logic        saw_break;
	} rec_state_t;

	rec_state_t st_q;
	rec_state_t st_nxt;
	logic       accept;
	logic       ok;
	logic [16:0] sum;

	logic        out_valid_q;
	logic        recognized_q;
	logic [15:0] text_length_q;
	logic [15:0] pad_length_q;

	// Only a last byte needs room in the result register.
	assign in_stall = out_valid_q && out_stall && last_byte;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		st_nxt = st_q;
		sum    = {1'b0, st_q.byte_total} + {1'b0, st_q.nul_run} + 17'd1;
		if (data_byte == CH_NUL) begin
			if (st_q.lead_pending) begin
				st_nxt.record_bad   = 1'b1;
				st_nxt.lead_pending = 1'b0;
			end
			if (st_q.nul_run < CNT_CAP) begin
				st_nxt.nul_run = st_q.nul_run + 16'd1;
			end
		end else begin
			// A NUL run followed by text is embedded, not padding.
			if (st_q.nul_run != 16'd0) begin
				st_nxt.record_bad = 1'b1;
			end
			if (st_q.lead_pending) begin
				if (!second_byte_ok(data_byte)) begin
					st_nxt.record_bad = 1'b1;
				end
				st_nxt.lead_pending = 1'b0;
			end else if (single_byte_ok(data_byte)) begin
				if ((data_byte == CH_LF) || (data_byte == CH_CR)) begin
					st_nxt.saw_break = 1'b1;
				end
			end else if (is_lead(data_byte)) begin
				st_nxt.lead_pending = 1'b1;
			end else begin
				st_nxt.record_bad = 1'b1;
			end
			st_nxt.byte_total = (sum > {1'b0, CNT_CAP}) ? CNT_CAP : sum[15:0];
			st_nxt.nul_run    = 16'd0;
		end
		ok = !st_nxt.record_bad && !st_nxt.lead_pending && st_nxt.saw_break &&
			(st_nxt.byte_total >= MIN_TEXT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last_byte) begin
					st_q        <= '0;
					out_valid_q <= 1'b1;
				end else begin
					st_q <= st_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			recognized_q  <= ok;
			text_length_q <= st_nxt.byte_total;
			pad_length_q  <= st_nxt.nul_run;
		end
	end

	assign out_valid   = out_valid_q;
	assign recognized  = recognized_q;
	assign text_length = text_length_q;
	assign pad_length  = pad_length_q;

endmodule

// ===== rtl/sjtrc_check.sv =====
module sjtrc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic        recognized,
	input logic [15:0] text_length,
	input logic [15:0] pad_length
);
	import sjtrc_pkg::*;

	// A result that is not taken stays presented.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A transfer of a last byte yields a result in the next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> out_valid)
		else $error("no result after last byte");

	// A byte that is not last never creates a result out of nothing.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && !in_stall && !last_byte |=> !out_valid)
		else $error("result without a last byte");

	// Input waits only for a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");

	// A recognized record always has enough text.
	a_min_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recognized |-> text_length >= MIN_TEXT)
		else $error("recognized record too short");

endmodule

bind sjis_text_record_check sjtrc_check u_sjtrc_check (.*);

// ===== tb/tb_sjis_text_record_check.sv =====
module tb_sjis_text_record_check;
	timeunit 1ns;
	timeprecision 1ps;

	import sjtrc_pkg::*;

	localparam int unsigned LEN_CAP = (LEN_MAX_DEF < 32'd65535) ? LEN_MAX_DEF : 32'd65535;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 700;
	localparam int DIR_ROWS     = 22;
	localparam int PRINT_MAX    = 40;

	typedef struct packed {
		logic        recognized;
		logic [15:0] text_len;
		logic [15:0] pad_len;
	} verdict_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		verdict_t   want;
	} dir_row_t;

	// Typed verdicts are given only on last bytes; all other last bytes use the predictor.
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// All-NUL record straight after reset.
		'{8'h00, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd1}},
		// Valid text with space, TAB, LF and two bytes of padding.
		'{8'h20, 1'b0, 1'b0, '0},
		'{8'h09, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b0, 1'b0, '0},
		'{8'h7E, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, '0},
		// A byte outside every character class.
		'{8'hFF, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd0}},
		// Double-byte characters at the ends of the lead and trail ranges, CR break.
		'{8'h81, 1'b0, 1'b0, '0},
		'{8'h40, 1'b0, 1'b0, '0},
		'{8'h0D, 1'b0, 1'b0, '0},
		'{8'hEF, 1'b0, 1'b0, '0},
		'{8'hFC, 1'b1, 1'b0, '0},
		// Lead byte followed by NUL padding.
		'{8'h9F, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd1}},
		// Lead byte as the last text byte.
		'{8'h0A, 1'b0, 1'b0, '0},
		'{8'hE0, 1'b1, 1'b1, '{1'b0, 16'd2, 16'd0}},
		// NUL inside the text.
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h41, 1'b1, 1'b1, '{1'b0, 16'd2, 16'd0}},
		// Kana with a break, but only three text bytes.
		'{8'hA1, 1'b0, 1'b0, '0},
		'{8'hDF, 1'b0, 1'b0, '0},
		'{8'h0A, 1'b1, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        recognized;
	logic [15:0] text_length;
	logic [15:0] pad_length;

	// Sideband that travels with each byte: a typed verdict for the directed rows.
	logic     cur_typed = 1'b0;
	verdict_t cur_want = '0;
	logic     hold_req = 1'b0;

	// Predictor state.
	logic [15:0] sc_total = '0;
	logic [15:0] sc_nul = '0;
	logic        sc_lead = 1'b0;
	logic        sc_bad = 1'b0;
	logic        sc_brk = 1'b0;

	verdict_t pending_verdicts[$];
	int       mismatches = 0;
	int       sent = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	logic     mon_done;
	verdict_t mon_pred;
	verdict_t mon_want;
	verdict_t mon_got;

	always #2 clk = ~clk;

	sjis_text_record_check uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.recognized  (recognized),
		.text_length (text_length),
		.pad_length  (pad_length)
	);

	function automatic logic is_plain(input logic [7:0] b);
		return b == CH_TAB || b == CH_LF || b == CH_CR ||
			(b >= PRINT_LO && b <= PRINT_HI) || (b >= KANA_LO && b <= KANA_HI);
	endfunction

	function automatic logic is_lead_byte(input logic [7:0] b);
		return (b >= LEAD_A_LO && b <= LEAD_A_HI) || (b >= LEAD_B_LO && b <= LEAD_B_HI);
	endfunction

	function automatic logic is_trail_byte(input logic [7:0] b);
		return (b >= TRAIL_A_LO && b <= TRAIL_A_HI) || (b >= TRAIL_B_LO && b <= TRAIL_B_HI);
	endfunction

	function automatic logic [7:0] rand_single();
		case ($urandom_range(0, 9))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_CR;
			3, 4, 5, 6: return 8'($urandom_range(PRINT_LO, PRINT_HI));
			default: return 8'($urandom_range(KANA_LO, KANA_HI));
		endcase
	endfunction

	function automatic logic [7:0] rand_lead();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(LEAD_A_LO, LEAD_A_HI));
		return 8'($urandom_range(LEAD_B_LO, LEAD_B_HI));
	endfunction

	// Advances the record scan by one byte; on a last byte it yields the verdict and clears.
	task automatic scan_byte(input logic [7:0] b, input logic l, output logic done,
			output verdict_t v);
		logic [16:0] sum;
		done = 1'b0;
		v = '0;
		if (b == CH_NUL) begin
			if (sc_lead) begin
				sc_bad = 1'b1;
				sc_lead = 1'b0;
			end
			if (sc_nul < LEN_CAP)
				sc_nul = sc_nul + 16'd1;
		end else begin
			if (sc_nul != 16'd0)
				sc_bad = 1'b1;
			if (sc_lead) begin
				if (!is_trail_byte(b))
					sc_bad = 1'b1;
				sc_lead = 1'b0;
			end else if (is_plain(b)) begin
				if (b == CH_LF || b == CH_CR)
					sc_brk = 1'b1;
			end else if (is_lead_byte(b)) begin
				sc_lead = 1'b1;
			end else begin
				sc_bad = 1'b1;
			end
			// Skipped NULs turn into text once a non-NUL byte follows them.
			sum = {1'b0, sc_total} + {1'b0, sc_nul} + 17'd1;
			sc_total = (sum > LEN_CAP) ? 16'(LEN_CAP) : sum[15:0];
			sc_nul = 16'd0;
		end
		if (l) begin
			done = 1'b1;
			v.recognized = !sc_bad && !sc_lead && sc_brk && sc_total >= MIN_TEXT;
			v.text_len = sc_total;
			v.pad_len = sc_nul;
			sc_total = '0;
			sc_nul = '0;
			sc_lead = 1'b0;
			sc_bad = 1'b0;
			sc_brk = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_MAX)
			$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	// Offers one byte and returns at the edge where its transfer happens.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
			input verdict_t want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(200, 400);
			else
				burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		cur_typed <= typed;
		cur_want <= want;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_random_record();
		logic [7:0] q[$];
		logic [7:0] b;
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					q.push_back(rand_lead());
					if ($urandom_range(0, 1) == 0)
						q.push_back(8'($urandom_range(TRAIL_A_LO, TRAIL_A_HI)));
					else
						q.push_back(8'($urandom_range(TRAIL_B_LO, TRAIL_B_HI)));
				end else begin
					q.push_back(rand_single());
				end
			end
			if (kind >= 70) begin
				pos = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 3))
					0: begin
						do b = 8'($urandom); while (b == CH_NUL || is_plain(b) || is_lead_byte(b));
						q[pos] = b;
					end
					1: q.insert(pos, CH_NUL);
					2: q.push_back(rand_lead());
					default: begin
						do b = 8'($urandom); while (is_trail_byte(b));
						q.insert(pos, b);
						q.insert(pos, rand_lead());
					end
				endcase
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) q.push_back(CH_NUL);
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				q.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
		end
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1, 1'b0, '0);
	endtask

	// Both transfers are judged here, the result first, so a fresh verdict never meets
	// a result of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				mon_got = '{recognized, text_length, pad_length};
				if (pending_verdicts.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected: %0b %0d %0d",
						mon_got.recognized, mon_got.text_len, mon_got.pad_len));
				end else begin
					mon_want = pending_verdicts.pop_front();
					if (mon_got.recognized !== mon_want.recognized)
						flag_mismatch($sformatf("recognized got %0b want %0b",
							mon_got.recognized, mon_want.recognized));
					if (mon_got.text_len !== mon_want.text_len)
						flag_mismatch($sformatf("text_length got %0d want %0d",
							mon_got.text_len, mon_want.text_len));
					if (mon_got.pad_len !== mon_want.pad_len)
						flag_mismatch($sformatf("pad_length got %0d want %0d",
							mon_got.pad_len, mon_want.pad_len));
				end
			end
			if (in_valid && !in_stall) begin
				scan_byte(data_byte, last_byte, mon_done, mon_pred);
				if (mon_done)
					pending_verdicts.push_back(cur_typed ? cur_want : mon_pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("[sjis_text_record_check] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver: randomly chosen stall modes, plus one long hold-off.
	initial begin
		int cnt;
		int mode;
		bit held;
		cnt = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				cnt++;
				if (cnt % 97 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					2: out_stall <= ((cnt % 5) < 2);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			send_byte(DIR_TAB[r].data, DIR_TAB[r].last, DIR_TAB[r].typed, DIR_TAB[r].want);

		while (sent < DIR_ROWS + RANDOM_ITEMS) begin
			if (!hold_req && sent >= HOLD_AT) begin
				// One-byte records pile up behind the held result and back up the input.
				hold_req <= 1'b1;
				repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
			end
			send_random_record();
		end

		repeat (4) send_random_record();

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[sjis_text_record_check] OK");
		else
			$display("[sjis_text_record_check] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sjtrc_pkg.sv
rtl/sjis_text_record_check.sv
rtl/sjtrc_check.sv
tb/tb_sjis_text_record_check.sv
